>>> sv/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants for the climate control step block
// Field widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int TEMP_W  = 12;
    localparam int LIGHT_W = 12;
    localparam int SP_W    = 9;
    localparam int DEG_W   = 9;
    localparam int PCT_W   = 7;
    localparam int DUTY_W  = 12;
    localparam int COIL_W  = 4;
    localparam int DIR_W   = 2;
    localparam int STEPS_W = 3;
    localparam int MAG_W   = 19;   // |light - bright| * 100 fits in 19 bits
    localparam int DIV_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

    // Register indexes on the configuration port (word address).
    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_BRIGHT   = 2'd1;
    localparam logic [1:0] REG_DARK     = 2'd2;

    localparam logic [SP_W-1:0]    SETPOINT_RST = 9'd23;
    localparam logic [LIGHT_W-1:0] BRIGHT_RST   = 12'd3139;
    localparam logic [LIGHT_W-1:0] DARK_RST     = 12'd1990;

    // Motor direction codes.
    localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
    localparam logic [DIR_W-1:0] DIR_CW   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_CCW  = 2'b11;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_init;
        logic emit;
    } ccs_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic last_pending;
    } ccs_sts_t;

endpackage

>>> sv/climate_control_step.sv
// ----------------------------------------------------------------------------
// climate_control_step: heater, stepper and LED control from one sample pair
// Configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one request per sample: temp_mv in s_tdata[11:0]
//   and light_mv in s_tdata[23:12]. The master stream gives one to six
//   results per sample, one per motor step (one when the motor is stopped),
//   with m_tlast on the final one.
//   The APB port holds setpoint_deg (0x0), light_bright_mv (0x4) and
//   light_dark_mv (0x8); write it only while no sample is in flight.
//   A sample is accepted, then passes through the bit-serial light divider,
//   one quotient bit per cycle, and its results are then issued in order,
//   one per motor step; the first is loaded once the divider is done and the
//   output register is free.
//   When the receiver stalls, the pending result holds in the output
//   register and the step sequence waits. The next sample is accepted once
//   the last result of the current one has been loaded into that register.
//   Reset returns the registers to their defaults and the stepper phase to 0.
// ----------------------------------------------------------------------------
module climate_control_step
#(
    parameter int DUTY_FULL_SCALE = 4095
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // temp_mv[11:0], light_mv[23:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    // heater_on[0], coil_drive[4:1], motor_direction[6:5], motor_steps[9:7],
    // temp_degrees[18:10], light_percent[25:19], pwm_duty[37:26], zero[39:38]
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [ccs_pkg::SP_W-1:0]    setpoint_reg;
    logic [ccs_pkg::LIGHT_W-1:0] bright_reg;
    logic [ccs_pkg::LIGHT_W-1:0] dark_reg;
    logic                        cfg_wr;
    logic [1:0]                  reg_idx;

    ccs_pkg::ccs_cmd_t           cmd;
    ccs_pkg::ccs_sts_t           sts;

    logic                        heater_on;
    logic [ccs_pkg::COIL_W-1:0]  coil_drive;
    logic [ccs_pkg::DIR_W-1:0]   motor_direction;
    logic [ccs_pkg::STEPS_W-1:0] motor_steps;
    logic [ccs_pkg::DEG_W-1:0]   temp_degrees;
    logic [ccs_pkg::PCT_W-1:0]   light_percent;
    logic [ccs_pkg::DUTY_W-1:0]  pwm_duty;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= ccs_pkg::SETPOINT_RST;
            bright_reg   <= ccs_pkg::BRIGHT_RST;
            dark_reg     <= ccs_pkg::DARK_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ccs_pkg::REG_SETPOINT: setpoint_reg <= pwdata[ccs_pkg::SP_W-1:0];
                ccs_pkg::REG_BRIGHT:   bright_reg   <= pwdata[ccs_pkg::LIGHT_W-1:0];
                ccs_pkg::REG_DARK:     dark_reg     <= pwdata[ccs_pkg::LIGHT_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ccs_pkg::REG_SETPOINT: prdata = 32'(setpoint_reg);
            ccs_pkg::REG_BRIGHT:   prdata = 32'(bright_reg);
            ccs_pkg::REG_DARK:     prdata = 32'(dark_reg);
            default:               prdata = '0;
        endcase
    end

    ccs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ccs_datapath
    #(
        .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .temp_mv         (s_tdata[11:0]),
        .light_mv        (s_tdata[23:12]),
        .setpoint_deg    (setpoint_reg),
        .light_bright_mv (bright_reg),
        .light_dark_mv   (dark_reg),
        .out_valid       (m_tvalid),
        .heater_on       (heater_on),
        .coil_drive      (coil_drive),
        .motor_direction (motor_direction),
        .motor_steps     (motor_steps),
        .temp_degrees    (temp_degrees),
        .light_percent   (light_percent),
        .pwm_duty        (pwm_duty),
        .last            (m_tlast)
    );

    assign m_tdata = {2'b00, pwm_duty, light_percent, temp_degrees, motor_steps,
                      motor_direction, coil_drive, heater_on};

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("sample accepted while the previous one is still in work");

    // A step drives exactly one coil; a stopped motor drives none.
    a_coil_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((motor_steps == 3'd0) ? (coil_drive == 4'd0) : $onehot(coil_drive)))
        else $error("coil pattern does not match the step count");

    // A stopped motor gives one result only.
    a_stop_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (motor_direction == ccs_pkg::DIR_STOP) |-> m_tlast)
        else $error("stopped motor produced more than one result");

    // Heating always goes with a single clockwise step.
    a_heater_cw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && heater_on |->
            (motor_direction == ccs_pkg::DIR_CW) && (motor_steps == 3'd1) && m_tlast)
        else $error("heater result is not a single clockwise step");

endmodule

>>> sv/ccs_ctrl.sv
// ----------------------------------------------------------------------------
// ccs_ctrl: sequencing controller
// Takes a sample, runs the light-span divider, then issues one result per step (one when stopped).
// ----------------------------------------------------------------------------
module ccs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_ready,
    input  ccs_pkg::ccs_sts_t sts,
    output ccs_pkg::ccs_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [ccs_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            slot_free;

    assign slot_free = !sts.out_valid || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ccs_pkg::DIV_LAST)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_pending)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> sv/ccs_datapath.sv
// ----------------------------------------------------------------------------
// ccs_datapath: sample arithmetic, divider, stepper phase and output register
// Temperature band, one-bit-per-cycle span divider and LED duty lookup.
// ----------------------------------------------------------------------------
module ccs_datapath
#(
    parameter int DUTY_FULL_SCALE = 4095
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ccs_pkg::ccs_cmd_t             cmd,
    output ccs_pkg::ccs_sts_t             sts,
    input  logic                          out_ready,
    input  logic [ccs_pkg::TEMP_W-1:0]    temp_mv,
    input  logic [ccs_pkg::LIGHT_W-1:0]   light_mv,
    input  logic [ccs_pkg::SP_W-1:0]      setpoint_deg,
    input  logic [ccs_pkg::LIGHT_W-1:0]   light_bright_mv,
    input  logic [ccs_pkg::LIGHT_W-1:0]   light_dark_mv,
    output logic                          out_valid,
    output logic                          heater_on,
    output logic [ccs_pkg::COIL_W-1:0]    coil_drive,
    output logic [ccs_pkg::DIR_W-1:0]     motor_direction,
    output logic [ccs_pkg::STEPS_W-1:0]   motor_steps,
    output logic [ccs_pkg::DEG_W-1:0]     temp_degrees,
    output logic [ccs_pkg::PCT_W-1:0]     light_percent,
    output logic [ccs_pkg::DUTY_W-1:0]    pwm_duty,
    output logic                          last
);

    localparam int MAG_W = ccs_pkg::MAG_W;
    localparam int LW    = ccs_pkg::LIGHT_W;

    // Duty for each LED level, worked out for the configured full scale.
    localparam logic [ccs_pkg::DUTY_W-1:0] DUTY_20  = 12'(20 * DUTY_FULL_SCALE / 100);
    localparam logic [ccs_pkg::DUTY_W-1:0] DUTY_40  = 12'(40 * DUTY_FULL_SCALE / 100);
    localparam logic [ccs_pkg::DUTY_W-1:0] DUTY_50  = 12'(50 * DUTY_FULL_SCALE / 100);
    localparam logic [ccs_pkg::DUTY_W-1:0] DUTY_70  = 12'(70 * DUTY_FULL_SCALE / 100);
    localparam logic [ccs_pkg::DUTY_W-1:0] DUTY_100 = 12'(DUTY_FULL_SCALE);

    // Division by ten as a multiply by 6554 / 2^16; exact for 12-bit inputs.
    localparam logic [12:0] RECIP_10 = 13'd6554;

    logic [24:0]                     deg_prod;
    logic signed [LW:0]              light_diff;
    logic [LW-1:0]                   light_abs;
    logic [MAG_W-1:0]                mag_load;

    logic [ccs_pkg::DEG_W-1:0]       deg_reg;
    logic                            neg_reg;
    logic                            span_pos_reg;
    logic [LW-1:0]                   span_reg;
    logic [LW-1:0]                   rem_reg;
    logic [MAG_W-1:0]                quo_reg;
    logic [1:0]                      phase_reg;
    logic [ccs_pkg::STEPS_W-1:0]     left_reg;

    logic [LW+1:0]                   trial;
    logic [9:0]                      deg_x, sp_x;
    logic                            heater_c;
    logic [ccs_pkg::DIR_W-1:0]       dir_c;
    logic [ccs_pkg::STEPS_W-1:0]     steps_c;
    logic [ccs_pkg::PCT_W-1:0]       pct_c;
    logic [ccs_pkg::DUTY_W-1:0]      duty_c;
    logic [1:0]                      coil_bit;

    logic                            out_valid_reg;
    logic                            heater_reg;
    logic [ccs_pkg::COIL_W-1:0]      coil_reg;
    logic [ccs_pkg::DIR_W-1:0]       dir_reg;
    logic [ccs_pkg::STEPS_W-1:0]     steps_reg;
    logic [ccs_pkg::DEG_W-1:0]       deg_out_reg;
    logic [ccs_pkg::PCT_W-1:0]       pct_reg;
    logic [ccs_pkg::DUTY_W-1:0]      duty_reg;
    logic                            last_reg;

    // Load path: degrees and the magnitude of the scaled light offset.
    assign deg_prod   = 25'(temp_mv) * 25'(RECIP_10);
    assign light_diff = $signed({1'b0, light_mv}) - $signed({1'b0, light_bright_mv});
    assign light_abs  = light_diff[LW] ? LW'(-light_diff) : light_diff[LW-1:0];
    assign mag_load   = MAG_W'(light_abs) * MAG_W'(100);

    assign trial = {1'b0, rem_reg, quo_reg[MAG_W-1]} - (LW+2)'(span_reg);

    // Temperature band against the setpoint.
    assign deg_x = {1'b0, deg_reg};
    assign sp_x  = {1'b0, setpoint_deg};

    always_comb
    begin
        heater_c = 1'b0;
        dir_c    = ccs_pkg::DIR_STOP;
        steps_c  = 3'd0;
        if (deg_x + 10'd1 < sp_x)
        begin
            heater_c = 1'b1;
            dir_c    = ccs_pkg::DIR_CW;
            steps_c  = 3'd1;
        end
        else if (deg_x <= sp_x + 10'd1)
        begin
            steps_c = 3'd0;
        end
        else if (deg_x <= sp_x + 10'd3)
        begin
            dir_c   = ccs_pkg::DIR_CCW;
            steps_c = 3'd1;
        end
        else if (deg_x <= sp_x + 10'd5)
        begin
            dir_c   = ccs_pkg::DIR_CCW;
            steps_c = 3'd3;
        end
        else
        begin
            dir_c   = ccs_pkg::DIR_CCW;
            steps_c = 3'd6;
        end
    end

    // A non-negative quotient always clamps to full scale, so only a
    // negative one needs the subtraction from 100.
    always_comb
    begin
        if (!span_pos_reg)
        begin
            pct_c = '0;
        end
        else if (!neg_reg)
        begin
            pct_c = 7'd100;
        end
        else if (quo_reg >= MAG_W'(100))
        begin
            pct_c = '0;
        end
        else
        begin
            pct_c = 7'd100 - quo_reg[ccs_pkg::PCT_W-1:0];
        end
    end

    always_comb
    begin
        if (pct_c < 7'd20)
        begin
            duty_c = '0;
        end
        else if (pct_c <= 7'd30)
        begin
            duty_c = DUTY_20;
        end
        else if (pct_c <= 7'd40)
        begin
            duty_c = DUTY_40;
        end
        else if (pct_c <= 7'd60)
        begin
            duty_c = DUTY_50;
        end
        else if (pct_c <= 7'd80)
        begin
            duty_c = DUTY_70;
        end
        else
        begin
            duty_c = DUTY_100;
        end
    end

    // Counter-clockwise drives coil 3-p, which is the inverted phase.
    assign coil_bit = (dir_c == ccs_pkg::DIR_CW) ? phase_reg : ~phase_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            deg_reg      <= deg_prod[24:16];
            neg_reg      <= light_diff[LW];
            span_pos_reg <= (light_bright_mv > light_dark_mv);
            span_reg     <= light_bright_mv - light_dark_mv;
            rem_reg      <= '0;
            quo_reg      <= mag_load;
        end
        else if (cmd.div_step)
        begin
            if (!trial[LW+1])
            begin
                rem_reg <= trial[LW-1:0];
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[LW-2:0], quo_reg[MAG_W-1]};
                quo_reg <= {quo_reg[MAG_W-2:0], 1'b0};
            end
        end

        if (cmd.emit)
        begin
            heater_reg  <= heater_c;
            coil_reg    <= (steps_c == 3'd0) ? 4'd0 : (4'd1 << coil_bit);
            dir_reg     <= dir_c;
            steps_reg   <= steps_c;
            deg_out_reg <= deg_reg;
            pct_reg     <= pct_c;
            duty_reg    <= duty_c;
            last_reg    <= (left_reg == 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit_init)
            begin
                left_reg <= (steps_c == 3'd0) ? 3'd1 : steps_c;
            end
            else if (cmd.emit)
            begin
                left_reg <= left_reg - 3'd1;
            end

            if (cmd.emit && (steps_c != 3'd0))
            begin
                phase_reg <= phase_reg + 2'd1;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.out_valid    = out_valid_reg;
    assign sts.last_pending = (left_reg == 3'd1);

    assign out_valid       = out_valid_reg;
    assign heater_on       = heater_reg;
    assign coil_drive      = coil_reg;
    assign motor_direction = dir_reg;
    assign motor_steps     = steps_reg;
    assign temp_degrees    = deg_out_reg;
    assign light_percent   = pct_reg;
    assign pwm_duty        = duty_reg;
    assign last            = last_reg;

endmodule

>>> tb/tb_climate_control_step.sv
// ----------------------------------------------------------------------------
// tb_climate_control_step: self-checking bench for the climate control step
// Drives sample requests on the slave stream and register writes on the APB
// port. Every result on the master stream is checked against a local model of
// the heater, stepper and LED logic: first a short directed table, then random
// samples under several register settings and stream idling patterns.
// ----------------------------------------------------------------------------
module tb_climate_control_step;

    localparam int DUTY_FS     = 4095;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEMS_PER_PHASE = 25;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        logic        heater;
        logic [3:0]  coil;
        logic [1:0]  dir;
        logic [2:0]  steps;
        logic [8:0]  deg;
        logic [6:0]  pct;
        logic [11:0] duty;
        logic        last;
    } step_res_t;

    // One row of the directed table. For a register row, reg_idx and a are
    // the register and value; for a sample row, a and b are temp and light.
    // Where chk is set, the typed fields replace the predicted ones.
    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [11:0] a;
        logic [11:0] b;
        logic        chk;
        logic        heater;
        logic [1:0]  dir;
        logic [2:0]  steps;
        logic [8:0]  deg;
        logic [6:0]  pct;
        logic [11:0] duty;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the block's registers and stepper phase.
    logic [8:0]  cfg_setpoint = ccs_pkg::SETPOINT_RST;
    logic [11:0] cfg_bright = ccs_pkg::BRIGHT_RST;
    logic [11:0] cfg_dark = ccs_pkg::DARK_RST;
    logic [1:0]  coil_phase = 2'd0;

    step_res_t   step_results_q[$];
    row_t        stim[$];
    int          err_count = 0;
    int          cycle_cnt = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    climate_control_step uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_climate_control_step: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic void predict_climate_step(input logic [11:0] t_mv,
                                                 input logic [11:0] l_mv);
        int          deg;
        int          sp;
        int          span;
        int          pct;
        int          led;
        int          n;
        logic        heat;
        logic [1:0]  dir;
        logic [2:0]  steps;
        logic [1:0]  bit_sel;
        step_res_t   r;
        deg = int'(t_mv) / 10;
        sp = int'(cfg_setpoint);
        span = int'(cfg_bright) - int'(cfg_dark);
        if (span <= 0)
            pct = 0;
        else
        begin
            // Signed division truncates toward zero before the offset of 100.
            pct = (100 * (int'(l_mv) - int'(cfg_bright))) / span + 100;
            if (pct < 0)
                pct = 0;
            if (pct > 100)
                pct = 100;
        end
        if (pct < 20)
            led = 100;
        else if (pct <= 30)
            led = 80;
        else if (pct <= 40)
            led = 60;
        else if (pct <= 60)
            led = 50;
        else if (pct <= 80)
            led = 30;
        else
            led = 0;
        heat = 1'b0;
        dir = ccs_pkg::DIR_STOP;
        steps = 3'd0;
        if (deg < sp - 1)
        begin
            heat = 1'b1;
            dir = ccs_pkg::DIR_CW;
            steps = 3'd1;
        end
        else if (deg <= sp + 1)
            steps = 3'd0;
        else if (deg <= sp + 3)
        begin
            dir = ccs_pkg::DIR_CCW;
            steps = 3'd1;
        end
        else if (deg <= sp + 5)
        begin
            dir = ccs_pkg::DIR_CCW;
            steps = 3'd3;
        end
        else
        begin
            dir = ccs_pkg::DIR_CCW;
            steps = 3'd6;
        end
        n = (steps == 3'd0) ? 1 : int'(steps);
        for (int k = 0; k < n; k++)
        begin
            r.coil = 4'd0;
            if (steps != 3'd0)
            begin
                bit_sel = (dir == ccs_pkg::DIR_CW) ? coil_phase : 2'd3 - coil_phase;
                r.coil = 4'd1 << bit_sel;
                coil_phase = coil_phase + 2'd1;
            end
            r.heater = heat;
            r.dir = dir;
            r.steps = steps;
            r.deg = deg[8:0];
            r.pct = pct[6:0];
            r.duty = 12'((100 - led) * DUTY_FS / 100);
            r.last = (k == n - 1);
            step_results_q.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        step_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (step_results_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got data 0x%010h last %0b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                e = step_results_q.pop_front();
                check_field("heater_on", e.heater, m_tdata[0]);
                check_field("coil_drive", e.coil, m_tdata[4:1]);
                check_field("motor_direction", e.dir, m_tdata[6:5]);
                check_field("motor_steps", e.steps, m_tdata[9:7]);
                check_field("temp_degrees", e.deg, m_tdata[18:10]);
                check_field("light_percent", e.pct, m_tdata[25:19]);
                check_field("pwm_duty", e.duty, m_tdata[37:26]);
                check_field("last", e.last, m_tlast);
            end
        end
    end

    // Called at a rising edge with no request pending on the slave side.
    task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            ccs_pkg::REG_SETPOINT: cfg_setpoint = val[8:0];
            ccs_pkg::REG_BRIGHT:   cfg_bright = val[11:0];
            ccs_pkg::REG_DARK:     cfg_dark = val[11:0];
            default:               ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Leaves tvalid high after acceptance so back-to-back requests keep it up.
    task automatic send_sample(input logic [11:0] t_mv, input logic [11:0] l_mv);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {l_mv, t_mv};
        do
            @(posedge clk);
        while (!s_tready);
        predict_climate_step(t_mv, l_mv);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (step_results_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int          n0;
        int          sp;
        int          off;
        int          tv;
        int          lv;
        int          lo;
        int          hi;
        int          dark_v;
        int          bright_v;
        row_t        row;

        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd0, 12'd3139, 1'b1,
                              1'b1, ccs_pkg::DIR_CW, 3'd1, 9'd0, 7'd100, 12'd4095});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd4095, 12'd0, 1'b1,
                              1'b0, ccs_pkg::DIR_CCW, 3'd6, 9'd409, 7'd0, 12'd0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd220, 12'd4095, 1'b1,
                              1'b0, ccs_pkg::DIR_STOP, 3'd0, 9'd22, 7'd100, 12'd4095});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd240, 12'd2564, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd250, 12'd2300, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd260, 12'd2000, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd270, 12'd2700, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd289, 12'd2900, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd290, 12'd2450, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd219, 12'd1990, 1'b1,
                              1'b1, ccs_pkg::DIR_CW, 3'd1, 9'd21, 7'd0, 12'd0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd230, 12'd2800, 1'b0, 0, 0, 0, 0, 0, 0});
        // Zero span, then a negative span: light reads as zero percent.
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_BRIGHT, 12'd1000, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_DARK, 12'd1000, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd230, 12'd3300, 1'b1,
                              1'b0, ccs_pkg::DIR_STOP, 3'd0, 9'd23, 7'd0, 12'd0});
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_DARK, 12'd2000, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd500, 12'd4095, 1'b1,
                              1'b0, ccs_pkg::DIR_CCW, 3'd6, 9'd50, 7'd0, 12'd0});
        // Setpoint beyond the sensor range, widest light span.
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_SETPOINT, 12'd511, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_BRIGHT, 12'd4095, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_DARK, 12'd0, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd4095, 12'd4095, 1'b1,
                              1'b1, ccs_pkg::DIR_CW, 3'd1, 9'd409, 7'd100, 12'd4095});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd0, 12'd0, 1'b1,
                              1'b1, ccs_pkg::DIR_CW, 3'd1, 9'd0, 7'd0, 12'd0});
        // Setpoint zero: the lower band edge goes negative.
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_SETPOINT, 12'd0, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd9, 12'd2048, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd10, 12'd1024, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd20, 12'd3072, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd59, 12'd512, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd60, 12'd3500, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_CFG, ccs_pkg::REG_SETPOINT, 12'd330, 12'd0, 1'b0,
                              0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd3300, 12'd1500, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd3289, 12'd2600, 1'b0, 0, 0, 0, 0, 0, 0});
        stim.push_back(row_t'{ROW_ITEM, 2'd0, 12'd3290, 12'd3700, 1'b0, 0, 0, 0, 0, 0, 0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim[i])
        begin
            row = stim[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                apb_write_reg(row.reg_idx, {20'd0, row.a});
            end
            else
            begin
                n0 = step_results_q.size();
                send_sample(row.a, row.b);
                if (row.chk)
                begin
                    for (int k = n0; k < step_results_q.size(); k++)
                    begin
                        step_results_q[k].heater = row.heater;
                        step_results_q[k].dir = row.dir;
                        step_results_q[k].steps = row.steps;
                        step_results_q[k].deg = row.deg;
                        step_results_q[k].pct = row.pct;
                        step_results_q[k].duty = row.duty;
                    end
                end
            end
        end

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
            endcase
            case (p)
                1:       sp = 0;
                3:       sp = 330;
                5:       sp = 511;
                default: sp = $urandom_range(330);
            endcase
            case (p)
                0: begin bright_v = 3300; dark_v = 0; end
                2: begin bright_v = 4095; dark_v = 0; end
                4:
                begin
                    dark_v = $urandom_range(3300, 1500);
                    bright_v = $urandom_range(dark_v - 1);
                end
                6:
                begin
                    dark_v = $urandom_range(4095);
                    bright_v = dark_v;
                end
                7:
                begin
                    // A one-millivolt span drives the percent far out of range.
                    dark_v = $urandom_range(3000);
                    bright_v = dark_v + 1;
                end
                default:
                begin
                    dark_v = $urandom_range(2000);
                    bright_v = dark_v + $urandom_range(1300, 1);
                end
            endcase
            apb_write_reg(ccs_pkg::REG_SETPOINT, sp);
            apb_write_reg(ccs_pkg::REG_BRIGHT, bright_v);
            apb_write_reg(ccs_pkg::REG_DARK, dark_v);

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // Most temperatures land near the setpoint so every band is hit.
                if ($urandom_range(99) < 80)
                begin
                    off = $urandom_range(16);
                    tv = (sp + off - 8) * 10 + $urandom_range(9);
                    if (tv < 0)
                        tv = 0;
                    if (tv > 4095)
                        tv = 4095;
                end
                else
                    tv = $urandom_range(4095);
                if (bright_v > dark_v && $urandom_range(99) < 85)
                begin
                    lo = (dark_v > 100) ? dark_v - 100 : 0;
                    hi = (bright_v < 3995) ? bright_v + 100 : 4095;
                    lv = $urandom_range(hi, lo);
                end
                else
                    lv = $urandom_range(4095);
                send_sample(tv[11:0], lv[11:0]);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("tb_climate_control_step: clean");
        else
            $display("tb_climate_control_step: errors");
        $finish;
    end

endmodule
